### src/pe_reloc_pkg.sv
// ----------------------------------------------------------------------------
// pe_reloc_pkg
// Shared types and constants for the base relocation block builder.
// ----------------------------------------------------------------------------
package pe_reloc_pkg;

  localparam int unsigned PageBits      = 12;
  localparam int unsigned MaxResults    = 6;
  localparam int unsigned SlotIdxW      = 3;
  localparam logic [3:0]  RelocTypeDir64 = 4'd10;
  localparam logic [31:0] HeaderBytes   = 32'd8;
  localparam logic [31:0] EntryBytes    = 32'd2;
  localparam logic [31:0] WordBytes     = 32'd4;

  localparam logic [1:0] KIND_ENTRY = 2'd0;
  localparam logic [1:0] KIND_PAGE  = 2'd1;
  localparam logic [1:0] KIND_SIZE  = 2'd2;
  localparam logic [1:0] KIND_PAD   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] offset;
    logic [31:0] value;
  } write_slot_t;

endpackage

### src/pe_base_reloc_block_builder_unit.sv
// ----------------------------------------------------------------------------
// pe_base_reloc_block_builder_unit
// Builds a PE base relocation table (DIR64) as byte-addressed writes from
// sorted fixups; one block per section/page run (a full entry count also starts a new block).
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | section_index, section_rva,
//          |           |                      | fixup_offset, last_fixup
//  out     | output    | out_valid/ out_ready | write_kind, byte_offset,
//          |           |                      | write_value, run_end
//
// Each item is decoded into 1 to 6 writes held in a result buffer; writes
// leave one per cycle while out_ready is high (one write for a plain entry).
// A new item is taken in the cycle the last buffered write leaves. rst is
// synchronous and clears the block and table state. out_ready low holds the
// buffer and, while writes are pending, stalls the input.
// ----------------------------------------------------------------------------
module pe_base_reloc_block_builder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  section_index,
  input  logic [31:0] section_rva,
  input  logic [31:0] fixup_offset,
  input  logic        last_fixup,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  write_kind,
  output logic [31:0] byte_offset,
  output logic [31:0] write_value,
  output logic        run_end
);

  localparam int unsigned IdxW = pe_reloc_pkg::SlotIdxW;

  // block / table state
  logic        block_open, block_open_next;
  logic [3:0]  open_section, open_section_next;
  logic [31:0] open_section_rva, open_section_rva_next;
  logic [31:0] open_page, open_page_next;
  logic [31:0] block_base, block_base_next;
  logic [12:0] entry_count, entry_count_next;
  logic [31:0] table_size, table_size_next;

  // result buffer
  pe_reloc_pkg::write_slot_t slots [pe_reloc_pkg::MaxResults];
  pe_reloc_pkg::write_slot_t slots_next [pe_reloc_pkg::MaxResults];
  logic [IdxW-1:0] ptr;
  logic [IdxW-1:0] remain;
  logic [IdxW-1:0] n_res;

  logic        in_fire, out_fire;
  logic [31:0] page, start_sum, start, entry_pos;
  logic        close_old, opening;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign in_ready = (remain == '0) || ((remain == IdxW'(1)) && out_ready);

  assign page      = {fixup_offset[31:pe_reloc_pkg::PageBits],
                      {pe_reloc_pkg::PageBits{1'b0}}};
  assign start_sum = table_size + 32'd3;
  assign start     = {start_sum[31:2], 2'b00};
  assign close_old = block_open && ((section_index != open_section) ||
                     (page != open_page) || (&entry_count));
  assign opening   = !block_open || close_old;
  assign entry_pos = opening ? (start + pe_reloc_pkg::HeaderBytes) : table_size;

  always_comb begin
    n_res                 = '0;
    block_open_next       = 1'b1;
    open_section_next     = open_section;
    open_section_rva_next = open_section_rva;
    open_page_next        = open_page;
    block_base_next       = block_base;
    entry_count_next      = entry_count + 13'd1;
    for (int i = 0; i < pe_reloc_pkg::MaxResults; i++) begin
      slots_next[i] = '0;
    end

    if (close_old) begin
      slots_next[0] = '{pe_reloc_pkg::KIND_PAGE, block_base,
                        open_section_rva + open_page};
      slots_next[1] = '{pe_reloc_pkg::KIND_SIZE, block_base + pe_reloc_pkg::WordBytes,
                        pe_reloc_pkg::HeaderBytes + {18'd0, entry_count, 1'b0}};
      n_res = IdxW'(2);
    end

    if (opening) begin
      if (table_size[1:0] != 2'b00) begin
        slots_next[n_res] = '{pe_reloc_pkg::KIND_PAD, table_size, 32'd0};
        n_res = n_res + IdxW'(1);
      end
      open_section_next     = section_index;
      open_section_rva_next = section_rva;
      open_page_next        = page;
      block_base_next       = start;
      entry_count_next      = 13'd1;
    end

    slots_next[n_res] = '{pe_reloc_pkg::KIND_ENTRY, entry_pos,
                          {16'd0, pe_reloc_pkg::RelocTypeDir64,
                           fixup_offset[pe_reloc_pkg::PageBits-1:0]}};
    n_res = n_res + IdxW'(1);

    if (last_fixup) begin
      slots_next[n_res] = '{pe_reloc_pkg::KIND_PAGE, block_base_next,
                            open_section_rva_next + open_page_next};
      slots_next[n_res + IdxW'(1)] = '{pe_reloc_pkg::KIND_SIZE,
                            block_base_next + pe_reloc_pkg::WordBytes,
                            pe_reloc_pkg::HeaderBytes +
                            {18'd0, entry_count_next, 1'b0}};
      n_res = n_res + IdxW'(2);
      block_open_next = 1'b0;
    end

    table_size_next = entry_pos + pe_reloc_pkg::EntryBytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_open       <= 1'b0;
      open_section     <= '0;
      open_section_rva <= '0;
      open_page        <= '0;
      block_base       <= '0;
      entry_count      <= '0;
      table_size       <= '0;
      ptr              <= '0;
      remain           <= '0;
    end else if (in_fire) begin
      block_open       <= block_open_next;
      open_section     <= open_section_next;
      open_section_rva <= open_section_rva_next;
      open_page        <= open_page_next;
      block_base       <= block_base_next;
      entry_count      <= entry_count_next;
      table_size       <= table_size_next;
      ptr              <= '0;
      remain           <= n_res;
    end else if (out_fire) begin
      ptr    <= ptr + IdxW'(1);
      remain <= remain - IdxW'(1);
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      slots <= slots_next;
    end
  end

  assign out_valid   = (remain != '0);
  assign write_kind  = slots[ptr].kind;
  assign byte_offset = slots[ptr].offset;
  assign write_value = slots[ptr].value;
  assign run_end     = (remain == IdxW'(1));

  // checks
  a_remain_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, ptr} + {1'b0, remain}) <= (IdxW+1)'(pe_reloc_pkg::MaxResults))
    else $error("result buffer overrun");

  a_load: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (remain != '0) && (ptr == '0))
    else $error("accepted item produced no writes");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_fixup |=> !block_open)
    else $error("block left open after final fixup");

  a_open_after: assert property (@(posedge clk) disable iff (rst)
    in_fire && !last_fixup |=> block_open && (table_size[0] == 1'b0))
    else $error("block not open or table size odd after entry");

endmodule
